>>> src/sac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the spike autocorrelogram block.
// ----------------------------------------------------------------------------
package sac_pkg;

	localparam int HALF_BINS   = 256;
	localparam int WIN_DEPTH   = 64;
	localparam int NBINS       = 2 * HALF_BINS;
	localparam int TIME_W      = 64;
	localparam int COUNT_W     = 32;
	localparam int BW_W        = 20;
	localparam int HB_W        = 9;
	localparam int IDX_W       = $clog2(NBINS);
	localparam int PTR_W       = $clog2(WIN_DEPTH);
	localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
	localparam int QUO_W       = $clog2(HALF_BINS);
	localparam int LIM_W       = HB_W + BW_W;
	localparam int REM_W       = BW_W + QUO_W;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_BINS = 1'd1;

	localparam logic OP_SPIKE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [TIME_W-1:0] spike_time;
		logic [IDX_W-1:0]  read_index;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} front_out_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} back_ctrl_t;

	typedef struct packed {
		logic [BW_W-1:0] bw;
		logic [HB_W-1:0] hb;
	} cfg_t;

endpackage

>>> src/sac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module sac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/sac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_front
// Input side: two-entry transaction queue in front of the sequencer.
// ----------------------------------------------------------------------------
module sac_front import sac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              opcode,
	input  logic [TIME_W-1:0] spike_time,
	input  logic [IDX_W-1:0]  read_index,
	input  back_ctrl_t        ctrl,
	output front_out_t        fout
);

	item_t      ent_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] cnt_q;
	logic       acc;
	logic       take;

	assign full = (cnt_q == 2'd2) || ctrl.clearing;
	assign acc  = push && !full;
	assign take = ctrl.take && (cnt_q != 2'd0);

	assign fout.valid = (cnt_q != 2'd0);
	assign fout.item  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wr_q] <= '{opcode: opcode, spike_time: spike_time, read_index: read_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) wr_q <= ~wr_q;
			if (take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, take};
		end
	end

endmodule

>>> src/sac_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_back
// Sequencer: histogram clear, window walk, bin divide, histogram update and bin reads.
// ----------------------------------------------------------------------------
module sac_back import sac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  front_out_t         fout,
	output back_ctrl_t         ctrl,
	input  logic               pop,
	output logic               empty,
	output logic [COUNT_W-1:0] bin_count,
	output logic               window_overflow,
	output logic               order_error
);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_START, ST_RD, ST_CMP, ST_DIV,
		ST_B1, ST_B1W, ST_B2, ST_B2W, ST_NEXT, ST_STORE, ST_RDBIN
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    clr_q;
	logic [TIME_W-1:0]   t_q;
	logic [TIME_W-1:0]   newest_q;
	logic [FILL_W-1:0]   fill_q;
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [FILL_W-1:0]   k_q;
	logic [LIM_W-1:0]    limit_q;
	logic [REM_W-1:0]    rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic [$clog2(QUO_W)-1:0] step_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_cnt_q;
	logic                out_ovf_q;
	logic                out_ord_q;
	logic                ovf_q;
	logic                ord_q;

	logic                s_we;
	logic [PTR_W-1:0]    s_raddr;
	logic [TIME_W-1:0]   s_rdata;
	logic                h_we;
	logic [IDX_W-1:0]    h_waddr;
	logic [COUNT_W-1:0]  h_wdata;
	logic [IDX_W-1:0]    h_raddr;
	logic [COUNT_W-1:0]  h_rdata;
	logic [IDX_W-1:0]    a1;
	logic [IDX_W-1:0]    a2;
	logic [TIME_W-1:0]   d;
	logic [REM_W-1:0]    dsub;
	logic [COUNT_W-1:0]  inc;
	logic [IDX_W:0]      nb;

	assign a1  = IDX_W'(cfg.hb - HB_W'(quo_q) - HB_W'(1));
	assign a2  = IDX_W'(cfg.hb + HB_W'(quo_q));
	assign d   = t_q - s_rdata;
	assign dsub = REM_W'({{QUO_W{1'b0}}, cfg.bw} << step_q);
	assign inc = (h_rdata == '1) ? h_rdata : h_rdata + COUNT_W'(1);
	assign nb  = {cfg.hb, 1'b0};
	assign s_raddr = PTR_W'({1'b0, wr_ptr_q} - fill_q + k_q);
	assign s_we = (state_q == ST_STORE);

	always_comb begin
		h_we    = 1'b0;
		h_waddr = a1;
		h_wdata = inc;
		h_raddr = a1;
		case (state_q)
			ST_CLR: begin
				h_we    = 1'b1;
				h_waddr = clr_q;
				h_wdata = '0;
			end
			ST_B1W: h_we = 1'b1;
			ST_B2:  h_raddr = a2;
			ST_B2W: begin
				h_we    = 1'b1;
				h_waddr = a2;
			end
			ST_IDLE: h_raddr = fout.item.read_index;
			default: h_raddr = a1;
		endcase
	end

	sac_ram #(.WIDTH(TIME_W), .DEPTH(WIN_DEPTH)) u_spikes (
		.clk(clk), .we(s_we), .waddr(wr_ptr_q), .wdata(t_q),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	sac_ram #(.WIDTH(COUNT_W), .DEPTH(NBINS)) u_hist (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	assign ctrl.clearing = (state_q == ST_CLR);
	assign ctrl.take = (state_q == ST_IDLE) && fout.valid
		&& !(fout.item.opcode == OP_READ && out_valid_q);

	assign empty           = !out_valid_q;
	assign bin_count       = out_cnt_q;
	assign window_overflow = out_ovf_q;
	assign order_error     = out_ord_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			fill_q      <= '0;
			wr_ptr_q    <= '0;
			out_valid_q <= 1'b0;
			ovf_q       <= 1'b0;
			ord_q       <= 1'b0;
			t_q         <= '0;
			newest_q    <= '0;
			k_q         <= '0;
			limit_q     <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			step_q      <= '0;
			out_cnt_q   <= '0;
			out_ovf_q   <= 1'b0;
			out_ord_q   <= 1'b0;
		end else begin
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(NBINS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (ctrl.take) begin
						t_q <= fout.item.spike_time;
						if (fout.item.opcode == OP_READ) begin
							out_ovf_q <= ovf_q;
							out_ord_q <= ord_q;
							if ({1'b0, fout.item.read_index} >= nb) begin
								out_cnt_q   <= '0;
								out_valid_q <= 1'b1;
							end else begin
								state_q <= ST_RDBIN;
							end
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_RDBIN: begin
					out_cnt_q   <= h_rdata;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_START: begin
					limit_q <= LIM_W'(cfg.hb) * LIM_W'(cfg.bw);
					k_q     <= '0;
					if (fill_q != '0 && t_q < newest_q) begin
						ord_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else if (fill_q == '0) begin
						state_q <= ST_STORE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					if (k_q == '0 && fill_q == FILL_W'(WIN_DEPTH)
						&& d < TIME_W'(limit_q)) begin
						ovf_q <= 1'b1;
					end
					if (d < TIME_W'(limit_q)) begin
						rem_q   <= d[REM_W-1:0];
						quo_q   <= '0;
						step_q  <= '1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_DIV: begin
					if (rem_q >= dsub) begin
						rem_q         <= rem_q - dsub;
						quo_q[step_q] <= 1'b1;
					end
					if (step_q == '0) state_q <= ST_B1;
					step_q <= step_q - 1'b1;
				end
				ST_B1:  state_q <= ST_B1W;
				ST_B1W: state_q <= ST_B2;
				ST_B2:  state_q <= ST_B2W;
				ST_B2W: state_q <= ST_NEXT;
				ST_NEXT: begin
					k_q <= k_q + FILL_W'(1);
					state_q <= (k_q + FILL_W'(1) == fill_q) ? ST_STORE : ST_RD;
				end
				ST_STORE: begin
					newest_q <= t_q;
					wr_ptr_q <= wr_ptr_q + PTR_W'(1);
					if (fill_q != FILL_W'(WIN_DEPTH)) fill_q <= fill_q + FILL_W'(1);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> src/spike_autocorrelogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spike_autocorrelogram
// Spike train autocorrelogram with saturating histogram and sticky flags.
// ----------------------------------------------------------------------------
// After reset all 512 histogram bins are cleared, during which full is high.
// A read in range goes through the histogram RAM port and the RDBIN state; an
// out-of-range index reads as zero. A spike walks the 64-entry window RAM
// through RD, CMP and NEXT per stored spike, and each pair in range adds an
// 8-bit bin divide and two read-modify-write updates of the histogram RAM. A
// two-entry queue takes new transactions while the sequencer works.
module spike_autocorrelogram import sac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BW_W-1:0]      cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 opcode,
	input  logic [TIME_W-1:0]    spike_time,
	input  logic [IDX_W-1:0]     read_index,
	output logic                 empty,
	input  logic                 pop,
	output logic [COUNT_W-1:0]   bin_count,
	output logic                 window_overflow,
	output logic                 order_error
);

	logic [BW_W-1:0] bw_q;
	logic [HB_W-1:0] hb_q;
	cfg_t            cfg;
	front_out_t      fout;
	back_ctrl_t      ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= BW_W'(1);
			hb_q <= HB_W'(HALF_BINS);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIN_WIDTH: bw_q <= cfg_data;
				REG_HALF_BINS: hb_q <= cfg_data[HB_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.bw = (bw_q == '0) ? BW_W'(1) : bw_q;
	assign cfg.hb = (hb_q == '0) ? HB_W'(1) :
		(hb_q > HB_W'(HALF_BINS)) ? HB_W'(HALF_BINS) : hb_q;

	sac_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .spike_time(spike_time), .read_index(read_index),
		.ctrl(ctrl), .fout(fout)
	);

	sac_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .fout(fout), .ctrl(ctrl),
		.pop(pop), .empty(empty), .bin_count(bin_count),
		.window_overflow(window_overflow), .order_error(order_error)
	);

endmodule
